FILE: sv/fpxp_pkg.sv
// Shared types and constants of the frame parser with XOR parity check.
package fpxp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned NibW  = 4;

  localparam logic [ByteW-1:0] MarkerReset = 8'd126;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_LEN  = 3'd1,
    PH_HDR  = 3'd2,
    PH_DATA = 3'd3,
    PH_PAR  = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_PARITY_ERR = 2'd1,
    ST_NO_MARKER  = 2'd2
  } status_e;

  localparam logic KindData = 1'b0;
  localparam logic KindEnd  = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] data_byte;
    logic [ByteW-1:0] frame_length;
    logic [NibW-1:0]  sequence_number;
    logic [NibW-1:0]  frame_type;
    status_e          status;
    logic             last;
  } result_t;

endpackage

FILE: sv/fpxp_core.sv
// Frame parsing state machine and result formation for data, parity and non-marker idle bytes.
module fpxp_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [fpxp_pkg::ByteW-1:0]  rx_byte_i,
  input  logic [fpxp_pkg::ByteW-1:0]  marker_i,
  output logic                        res_valid_o,
  output fpxp_pkg::result_t           res_o
);
  import fpxp_pkg::*;

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] bytes_left_q, bytes_left_d;
  logic [ByteW-1:0] parity_acc_q, parity_acc_d;
  logic [ByteW-1:0] held_length_q, held_length_d;
  logic [NibW-1:0]  held_sequence_q, held_sequence_d;
  logic [NibW-1:0]  held_type_q, held_type_d;

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (accept_i) begin
      unique case (phase_q)
        PH_LEN:  phase_d = PH_HDR;
        PH_HDR:  phase_d = (held_length_q != '0) ? PH_DATA : PH_PAR;
        PH_DATA: phase_d = (bytes_left_q == ByteW'(1)) ? PH_PAR : PH_DATA;
        PH_PAR:  phase_d = PH_IDLE;
        default: phase_d = (rx_byte_i == marker_i) ? PH_LEN : PH_IDLE;
      endcase
    end
  end

  // Held header fields, byte count and running parity
  always_comb begin
    bytes_left_d    = bytes_left_q;
    parity_acc_d    = parity_acc_q;
    held_length_d   = held_length_q;
    held_sequence_d = held_sequence_q;
    held_type_d     = held_type_q;
    if (accept_i) begin
      unique case (phase_q)
        PH_LEN: begin
          held_length_d = rx_byte_i;
        end
        PH_HDR: begin
          held_sequence_d = rx_byte_i[ByteW-1:NibW];
          held_type_d     = rx_byte_i[NibW-1:0];
          parity_acc_d    = '0;
          bytes_left_d    = held_length_q;
        end
        PH_DATA: begin
          parity_acc_d = parity_acc_q ^ rx_byte_i;
          bytes_left_d = bytes_left_q - ByteW'(1);
        end
        default: ;
      endcase
    end
  end

  // Result for the accepted byte
  always_comb begin
    res_valid_o           = 1'b0;
    res_o.kind            = KindEnd;
    res_o.data_byte       = '0;
    res_o.frame_length    = held_length_q;
    res_o.sequence_number = held_sequence_q;
    res_o.frame_type      = held_type_q;
    res_o.status          = ST_OK;
    res_o.last            = 1'b1;
    unique case (phase_q)
      PH_LEN, PH_HDR: ;
      PH_DATA: begin
        res_valid_o     = accept_i;
        res_o.kind      = KindData;
        res_o.data_byte = rx_byte_i;
        res_o.last      = 1'b0;
      end
      PH_PAR: begin
        res_valid_o = accept_i;
        // zero-length frames are not checked
        if (held_length_q != '0 && rx_byte_i != parity_acc_q) begin
          res_o.status = ST_PARITY_ERR;
        end
      end
      default: begin
        res_valid_o           = accept_i && (rx_byte_i != marker_i);
        res_o.frame_length    = '0;
        res_o.sequence_number = '0;
        res_o.frame_type      = '0;
        res_o.status          = ST_NO_MARKER;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_IDLE;
      bytes_left_q    <= '0;
      parity_acc_q    <= '0;
      held_length_q   <= '0;
      held_sequence_q <= '0;
      held_type_q     <= '0;
    end else begin
      phase_q         <= phase_d;
      bytes_left_q    <= bytes_left_d;
      parity_acc_q    <= parity_acc_d;
      held_length_q   <= held_length_d;
      held_sequence_q <= held_sequence_d;
      held_type_q     <= held_type_d;
    end
  end

  a_data_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> bytes_left_q != '0)
    else $error("data phase with no bytes left");

  a_parity_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && phase_q == PH_PAR |=> phase_q == PH_IDLE)
    else $error("parity byte did not close the frame");

  a_empty_frame_skips_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && phase_q == PH_HDR && held_length_q == '0 |=> phase_q == PH_PAR)
    else $error("zero-length frame entered data phase");

endmodule

FILE: sv/frame_parser_xor_parity.sv
// Top level: byte-stream frame parser with XOR parity check and APB register.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------
//  in      | sink      | in_valid_i / in_stall_o   | rx_byte_i
//  out     | source    | out_valid_o / out_stall_i | kind_o, data_byte_o, frame_length_o,
//          |           |                           | sequence_number_o, frame_type_o,
//          |           |                           | status_o, last_o
//  cfg     | APB slave | psel/penable/pready       | paddr, pwdata, prdata
//
//  One byte is accepted per cycle while in_stall_o is low; its result, if any, is registered.
//  A two-entry output buffer (result register plus skid register) sets the rate.
//  in_stall_o rises only while the skid register holds a request.
//  Reset brings the parser to idle and the marker register to 126.
module frame_parser_xor_parity (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [fpxp_pkg::ByteW-1:0]   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         kind_o,
  output logic [fpxp_pkg::ByteW-1:0]   data_byte_o,
  output logic [fpxp_pkg::ByteW-1:0]   frame_length_o,
  output logic [fpxp_pkg::NibW-1:0]    sequence_number_o,
  output logic [fpxp_pkg::NibW-1:0]    frame_type_o,
  output logic [1:0]                   status_o,
  output logic                         last_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import fpxp_pkg::*;

  logic [ByteW-1:0] marker_q;
  logic             in_accept;
  logic             res_valid;
  result_t          res;
  logic             out_valid_q, skid_valid_q;
  result_t          out_q, skid_q;
  logic             out_free;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {24'd0, marker_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= MarkerReset;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      marker_q <= pwdata[ByteW-1:0];
    end
  end

  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !in_stall_o;

  fpxp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .rx_byte_i   (rx_byte_i),
    .marker_i    (marker_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output slot frees when empty or taken this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_free) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end
      end else if (res_valid) begin
        if (out_free) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_free) begin
        out_q <= skid_q;
      end
    end else if (res_valid) begin
      if (out_free) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = out_q.kind;
  assign data_byte_o       = out_q.data_byte;
  assign frame_length_o    = out_q.frame_length;
  assign sequence_number_o = out_q.sequence_number;
  assign frame_type_o      = out_q.frame_type;
  assign status_o          = out_q.status;
  assign last_o            = out_q.last;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a request ahead of the output register");

  a_out_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_q))
    else $error("stalled result changed or dropped");

  a_no_result_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !skid_valid_q)
    else $error("result formed while the skid register is full");

endmodule
